// ----- sv/fbpfc_pkg.sv -----
package fbpfc_pkg;

   // Color channels, ordered as their bytes sit in a BGRX-8888 word
   localparam int unsigned N_CHAN   = 3;
   localparam int unsigned CH_BLUE  = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_RED   = 2;

   // One quotient bit per restoring divide step; a channel is 8 bits
   localparam int unsigned DIV_STEPS = 8;

   localparam logic ACT_PUT = 1'b0;
   localparam logic ACT_GET = 1'b1;

   typedef logic [2:0]  csr_index_type;
   typedef logic [31:0] word_type;
   typedef logic [4:0]  shift_type;
   typedef logic [32:0] span_type;   // (mask >> low bit) + 1, up to 2^32
   typedef logic [33:0] rem_type;    // divide remainder, doubled before compare
   typedef logic [40:0] prod_type;   // channel * span
   typedef logic [7:0]  chan_type;
   typedef logic [14:0] dim_type;

   localparam csr_index_type REG_SCREEN_WIDTH  = 3'd0;
   localparam csr_index_type REG_SCREEN_HEIGHT = 3'd1;
   localparam csr_index_type REG_LINE_PITCH    = 3'd2;
   localparam csr_index_type REG_FB_SIZE_BYTES = 3'd3;
   localparam csr_index_type REG_RED_MASK      = 3'd4;
   localparam csr_index_type REG_GREEN_MASK    = 3'd5;
   localparam csr_index_type REG_BLUE_MASK     = 3'd6;

   localparam word_type  RESET_MASK  [N_CHAN] = '{32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
   localparam shift_type RESET_SHIFT [N_CHAN] = '{5'd0, 5'd8, 5'd16};
   localparam span_type  RESET_SPAN  [N_CHAN] = '{33'd256, 33'd256, 33'd256};

   // Front stage: products and field extraction
   typedef struct packed {
      logic                     action;
      logic                     pos_ok;
      logic [28:0]              row_base;
      logic [13:0]              col;
      word_type                 keep;
      prod_type [N_CHAN-1:0]    prod;
      rem_type  [N_CHAN-1:0]    rem;
   } front_type;

   // Divide stages: one quotient bit per channel per stage
   typedef struct packed {
      logic                     action;
      logic                     pos_ok;
      logic                     fit_ok;
      word_type                 offset;
      word_type                 put_word;
      rem_type  [N_CHAN-1:0]    rem;
      chan_type [N_CHAN-1:0]    quo;
   } pipe_type;

   typedef struct packed {
      rem_type rem;
      logic    qbit;
   } step_type;

endpackage

// ----- sv/framebuffer_pixel_format_converter.sv -----
// Stages: a front stage, eight restoring divide stages for the get path and an output
// register lie between the edge that accepts an item and the offered result.
// Throughput: one item per cycle unless the result side stalls; each stage has its own valid
// bit and a stalled result holds only the stages behind it that are full.
// Reset: synchronous, active high; empties the pipeline and loads register defaults
// (sizes 0, masks for red 23..16, green 15..8, blue 7..0).
module framebuffer_pixel_format_converter #(
   parameter int unsigned MAX_DIM = 16384
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [13:0]             req_pixel_col,
   input  logic [13:0]             req_pixel_row,
   input  logic [31:0]             req_color_in,
   input  logic [31:0]             req_fb_word_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_in_range,
   output logic [31:0]             rsp_byte_offset,
   output logic [31:0]             rsp_word_out,
   input  logic                    csr_write_en,
   input  fbpfc_pkg::csr_index_type csr_index,
   input  fbpfc_pkg::word_type      csr_wdata
);
   import fbpfc_pkg::*;

   // Stage 0 is the front, 1..DIV_STEPS divide, the last one is the output register
   localparam int unsigned N_STAGES = DIV_STEPS + 2;
   localparam int unsigned OUT_IDX  = N_STAGES - 1;

   // Lowest set bit of a mask; an empty mask reports 31, which with a span of 1
   // makes the channel read and write as zero without a special case.
   function automatic shift_type low_bit(word_type m);
      shift_type s;
      s = 5'd31;
      for (int i = 31; i >= 0; i--) begin
         if (m[i]) begin
            s = 5'(i);
         end
      end
      return s;
   endfunction

   // One restoring divide step: remainder stays below the span
   function automatic step_type div_step(rem_type r, span_type n);
      step_type res;
      rem_type  r2;
      r2 = {r[32:0], 1'b0};
      if (r2 >= 34'(n)) begin
         res.rem  = r2 - 34'(n);
         res.qbit = 1'b1;
      end else begin
         res.rem  = r2;
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers. Shift and span of each mask are derived on
   // the write so that the datapath only sees ready-made values.
   // ------------------------------------------------------------------
   dim_type   width_ff, height_ff, pitch_ff;
   word_type  fb_size_ff;
   word_type  mask_ff  [N_CHAN];
   shift_type shift_ff [N_CHAN];
   span_type  span_ff  [N_CHAN];

   dim_type   wr_dim;
   shift_type wr_shift;
   span_type  wr_span;

   always_comb begin
      // Screen sizes saturate at the largest supported dimension
      if (32'(csr_wdata[14:0]) > MAX_DIM) begin
         wr_dim = 15'(MAX_DIM);
      end else begin
         wr_dim = csr_wdata[14:0];
      end
      wr_shift = low_bit(csr_wdata);
      wr_span  = 33'({1'b0, csr_wdata} >> wr_shift) + 33'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= '0;
         height_ff  <= '0;
         pitch_ff   <= '0;
         fb_size_ff <= '0;
         for (int c = 0; c < N_CHAN; c++) begin
            mask_ff[c]  <= RESET_MASK[c];
            shift_ff[c] <= RESET_SHIFT[c];
            span_ff[c]  <= RESET_SPAN[c];
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_ff   <= wr_dim;
            REG_SCREEN_HEIGHT: height_ff  <= wr_dim;
            REG_LINE_PITCH:    pitch_ff   <= csr_wdata[14:0];
            REG_FB_SIZE_BYTES: fb_size_ff <= csr_wdata;
            REG_RED_MASK: begin
               mask_ff[CH_RED]  <= csr_wdata;
               shift_ff[CH_RED] <= wr_shift;
               span_ff[CH_RED]  <= wr_span;
            end
            REG_GREEN_MASK: begin
               mask_ff[CH_GREEN]  <= csr_wdata;
               shift_ff[CH_GREEN] <= wr_shift;
               span_ff[CH_GREEN]  <= wr_span;
            end
            REG_BLUE_MASK: begin
               mask_ff[CH_BLUE]  <= csr_wdata;
               shift_ff[CH_BLUE] <= wr_shift;
               span_ff[CH_BLUE]  <= wr_span;
            end
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Per-stage flow control: a stage takes new data when it is empty or
   // its content moves on in the same cycle.
   // ------------------------------------------------------------------
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES:0]   ready;

   always_comb begin
      ready[N_STAGES] = rsp_ready;
      for (int i = N_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign req_ready = ready[0];

   // ------------------------------------------------------------------
   // Front stage: row times pitch, channel times span for put, field
   // extraction for get, screen bounds.
   // ------------------------------------------------------------------
   front_type front_in, front_ff;

   always_comb begin
      front_in.action   = req_action;
      front_in.pos_ok   = ({1'b0, req_pixel_col} < width_ff) &&
                          ({1'b0, req_pixel_row} < height_ff);
      front_in.row_base = 29'(req_pixel_row) * 29'(pitch_ff);
      front_in.col      = req_pixel_col;
      front_in.keep     = req_fb_word_in &
                          ~(mask_ff[CH_RED] | mask_ff[CH_GREEN] | mask_ff[CH_BLUE]);
      for (int c = 0; c < N_CHAN; c++) begin
         front_in.prod[c] = 41'(req_color_in[8*c +: 8]) * 41'(span_ff[c]);
         front_in.rem[c]  = 34'((req_fb_word_in & mask_ff[c]) >> shift_ff[c]);
      end
   end

   // ------------------------------------------------------------------
   // Divide stages. Stage 1 also forms the offset and the merged put word;
   // stage 2 checks the offset against the framebuffer size at full width.
   // ------------------------------------------------------------------
   pipe_type pipe_in [1:DIV_STEPS];
   pipe_type pipe_ff [1:DIV_STEPS];

   always_comb begin
      logic [32:0] field;
      step_type    st;
      // Stage 1
      pipe_in[1].action   = front_ff.action;
      pipe_in[1].pos_ok   = front_ff.pos_ok;
      pipe_in[1].fit_ok   = 1'b0;
      pipe_in[1].offset   = {30'(front_ff.row_base) + 30'(front_ff.col), 2'b00};
      pipe_in[1].put_word = front_ff.keep;
      for (int c = 0; c < N_CHAN; c++) begin
         // put: top bits of the scaled channel, placed at the field's low bit
         field = front_ff.prod[c][40:8] << shift_ff[c];
         pipe_in[1].put_word = pipe_in[1].put_word | field[31:0];
         st = div_step(front_ff.rem[c], span_ff[c]);
         pipe_in[1].rem[c] = st.rem;
         pipe_in[1].quo[c] = {7'd0, st.qbit};
      end
      // Stages 2 and on: one more quotient bit each
      for (int k = 2; k <= DIV_STEPS; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         if (k == 2) begin
            pipe_in[k].fit_ok = (33'(pipe_ff[k-1].offset) + 33'd4) <= 33'(fb_size_ff);
         end
         for (int c = 0; c < N_CHAN; c++) begin
            st = div_step(pipe_ff[k-1].rem[c], span_ff[c]);
            pipe_in[k].rem[c] = st.rem;
            pipe_in[k].quo[c] = {pipe_ff[k-1].quo[c][6:0], st.qbit};
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: pick put or get word, zero it when out of range.
   // ------------------------------------------------------------------
   logic     ok;
   word_type word_in;
   logic     in_range_ff;
   word_type offset_ff, word_ff;

   always_comb begin
      ok = pipe_ff[DIV_STEPS].pos_ok && pipe_ff[DIV_STEPS].fit_ok;
      if (!ok) begin
         word_in = '0;
      end else if (pipe_ff[DIV_STEPS].action == ACT_GET) begin
         word_in = {8'd0, pipe_ff[DIV_STEPS].quo[CH_RED],
                    pipe_ff[DIV_STEPS].quo[CH_GREEN], pipe_ff[DIV_STEPS].quo[CH_BLUE]};
      end else begin
         word_in = pipe_ff[DIV_STEPS].put_word;
      end
   end

   // Valid bits: cleared by reset, advance with their stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < N_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Payload: no reset, moves only where the stage advances
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         front_ff <= front_in;
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         if (ready[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (ready[OUT_IDX]) begin
         in_range_ff <= ok;
         offset_ff   <= pipe_ff[DIV_STEPS].offset;
         word_ff     <= word_in;
      end
   end

   assign rsp_valid       = valid_ff[OUT_IDX];
   assign rsp_in_range    = in_range_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_word_out    = word_ff;

endmodule

// ----- sv/fbpfc_checker.sv -----
module fbpfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_in_range,
   input logic [31:0] rsp_byte_offset,
   input logic [31:0] rsp_word_out
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_out) &&
      $stable(rsp_byte_offset) && $stable(rsp_in_range))
      else $error("stalled result changed");

   // Out-of-range pixels carry no word
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_word_out == 32'd0)
      else $error("nonzero word for out-of-range pixel");

   // Offsets address whole 32-bit words
   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_offset[1:0] == 2'b00)
      else $error("unaligned byte offset");

endmodule

bind framebuffer_pixel_format_converter fbpfc_checker u_fbpfc_checker (.*);

// ----- dv/tb_framebuffer_pixel_format_converter.sv -----
module tb_framebuffer_pixel_format_converter;
   import fbpfc_pkg::*;

   localparam int unsigned SCREEN_DIM_MAX    = 16384;
   localparam int unsigned COORD_MAX         = 16383;
   // Index 7 is not a register; writes to it must leave the block untouched
   localparam csr_index_type REG_UNUSED      = 3'd7;
   localparam int unsigned N_REG_WRITES      = 8;
   localparam int unsigned RANDOM_SETTINGS   = 6;
   localparam int unsigned ITEMS_PER_SETTING = 250;
   localparam int unsigned PRESSURE_SETTING  = 4;
   localparam int unsigned PRESSURE_HOLD     = 80;
   // Run on after the last result so that stray results can show
   localparam int unsigned DRAIN_CYCLES      = 30;
   localparam int unsigned WATCHDOG_LIMIT    = 4000;

   typedef struct packed {
      logic        action;
      logic [13:0] col;
      logic [13:0] row;
      word_type    color;
      word_type    fb_word;
   } pixel_req_type;

   typedef struct packed {
      logic     in_range;
      word_type byte_offset;
      word_type word_out;
   } pixel_result_type;

   // Every block input starts at a known value
   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_ready;
   logic          req_action     = ACT_PUT;
   logic [13:0]   req_pixel_col  = '0;
   logic [13:0]   req_pixel_row  = '0;
   word_type      req_color_in   = '0;
   word_type      req_fb_word_in = '0;
   logic          rsp_valid;
   logic          rsp_ready      = 1'b0;
   logic          rsp_in_range;
   word_type      rsp_byte_offset;
   word_type      rsp_word_out;
   logic          csr_write_en   = 1'b0;
   csr_index_type csr_index      = REG_SCREEN_WIDTH;
   word_type      csr_wdata      = '0;

   // Shadow copy of the register file, updated when the block sees a write
   dim_type  cfg_width;
   dim_type  cfg_height;
   dim_type  cfg_pitch;
   word_type cfg_fb_bytes;
   word_type cfg_mask [N_CHAN];

   pixel_req_type    pixel_q[$];       // items waiting to be offered
   pixel_result_type converted_q[$];   // predicted results, oldest first

   logic        req_fire      = 1'b0;
   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 81;
   logic        pressure_arm  = 1'b0;
   logic        pressure_done = 1'b0;
   int unsigned hold_left     = 0;

   int unsigned pixels_queued  = 0;
   int unsigned pixels_taken   = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatches     = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned stall_cycles   = 0;
   int unsigned put_count      = 0;
   int unsigned get_count      = 0;
   int unsigned on_screen      = 0;
   int unsigned settings_done  = 0;

   framebuffer_pixel_format_converter #(
      .MAX_DIM (SCREEN_DIM_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .req_color_in    (req_color_in),
      .req_fb_word_in  (req_fb_word_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_in_range    (rsp_in_range),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_word_out    (rsp_word_out),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Conversion predictor
   // ------------------------------------------------------------------

   // Lowest set bit of a mask; stops at 31 like the hardware search
   function automatic int unsigned mask_lsb(word_type mask);
      int unsigned lsb;
      lsb = 0;
      while (lsb < 31 && !mask[lsb]) lsb++;
      return lsb;
   endfunction

   // Scale an 8-bit channel into the field: level * (field span) / 256, placed
   // at the low bit of the mask. No masking afterwards, so a mask with holes
   // can spill bits outside its field.
   function automatic word_type pack_channel(chan_type level, word_type mask);
      int unsigned lsb;
      logic [63:0] scaled;
      if (mask == '0) return '0;
      lsb    = mask_lsb(mask);
      scaled = (64'(level) * (64'(mask >> lsb) + 64'd1)) >> 8;
      scaled = scaled << lsb;
      return scaled[31:0];
   endfunction

   // Pull a field out and stretch it to 8 bits: field * 256 / span
   function automatic chan_type unpack_channel(word_type fb_word, word_type mask);
      int unsigned lsb;
      logic [63:0] scaled;
      if (mask == '0) return '0;
      lsb    = mask_lsb(mask);
      scaled = (64'((fb_word & mask) >> lsb) << 8) / (64'(mask >> lsb) + 64'd1);
      return scaled[7:0];
   endfunction

   function automatic pixel_result_type convert_pixel(pixel_req_type px);
      pixel_result_type res;
      logic [63:0]      offset;
      word_type         covered;
      // Keep the offset at full width so the bounds check can never wrap
      offset          = (64'(px.row) * 64'(cfg_pitch) + 64'(px.col)) << 2;
      res.byte_offset = offset[31:0];
      res.in_range    = (px.col < cfg_width) && (px.row < cfg_height) &&
                        (offset + 64'd4 <= 64'(cfg_fb_bytes));
      res.word_out    = '0;
      if (res.in_range) begin
         if (px.action == ACT_PUT) begin
            covered      = cfg_mask[CH_RED] | cfg_mask[CH_GREEN] | cfg_mask[CH_BLUE];
            res.word_out = (px.fb_word & ~covered)
                         | pack_channel(px.color[23:16], cfg_mask[CH_RED])
                         | pack_channel(px.color[15:8],  cfg_mask[CH_GREEN])
                         | pack_channel(px.color[7:0],   cfg_mask[CH_BLUE]);
         end else begin
            res.word_out = {8'h00,
                            unpack_channel(px.fb_word, cfg_mask[CH_RED]),
                            unpack_channel(px.fb_word, cfg_mask[CH_GREEN]),
                            unpack_channel(px.fb_word, cfg_mask[CH_BLUE])};
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic void push_pixel(logic act, int unsigned col, int unsigned row,
                                      word_type color, word_type fb_word);
      pixel_q.push_back('{act, 14'(col), 14'(row), color, fb_word});
      pixels_queued++;
   endfunction

   // Mostly on screen, some right at the edge, some anywhere in the field
   function automatic int unsigned pick_coord(dim_type limit);
      int unsigned sel;
      int unsigned pick;
      sel = $urandom_range(19);
      if (sel < 13 && limit != 0) pick = $urandom_range(0, limit - 1);
      else if (sel < 16)          pick = limit + $urandom_range(0, 2) - 1;
      else                        pick = $urandom_range(0, COORD_MAX);
      return (pick > COORD_MAX) ? COORD_MAX : pick;
   endfunction

   // Mostly contiguous fields of typical width; sometimes empty, full or ragged
   function automatic word_type random_mask();
      int unsigned bits;
      int unsigned lsb;
      word_type    mask;
      case ($urandom_range(9))
         0: mask = '0;
         1: mask = '1;
         2: mask = $urandom();
         default: begin
            bits = $urandom_range(1, 12);
            lsb  = $urandom_range(0, 32 - bits);
            mask = word_type'(((64'd1 << bits) - 64'd1) << lsb);
         end
      endcase
      return mask;
   endfunction

   // Write every register back to back, then the unused index with junk.
   // Call on a falling edge with the block idle.
   task automatic program_setting(word_type width, word_type height, word_type pitch,
                                  word_type fb_bytes, word_type red, word_type green,
                                  word_type blue);
      csr_index_type reg_order [N_REG_WRITES];
      word_type      value     [N_REG_WRITES];
      reg_order = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_LINE_PITCH,
                    REG_FB_SIZE_BYTES, REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK,
                    REG_UNUSED};
      value     = '{width, height, pitch, fb_bytes, red, green, blue, $urandom()};
      for (int i = 0; i < N_REG_WRITES; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= reg_order[i];
         csr_wdata    <= value[i];
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
      settings_done++;
   endtask

   // Hold until every queued item went in and every result came back
   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_taken != pixels_queued || converted_q.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Driver: offer items from the queue, change inputs on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_pixels
      pixel_req_type px;
      // Advance only when the slot is empty or the last item was just taken
      if (!reset && (!req_valid || req_fire)) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            px              = pixel_q.pop_front();
            req_valid      <= 1'b1;
            req_action     <= px.action;
            req_pixel_col  <= px.col;
            req_pixel_row  <= px.row;
            req_color_in   <= px.color;
            req_fb_word_in <= px.fb_word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when armed so the
   // pipeline fills and pushes back on the input
   always @(negedge clock) begin : drive_rsp_ready
      if (pressure_arm && !pressure_done) begin
         hold_left     = PRESSURE_HOLD;
         pressure_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: track register writes, predict on input, check on output
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      pixel_req_type    seen;
      pixel_result_type want;
      if (reset) begin
         cfg_width    = '0;
         cfg_height   = '0;
         cfg_pitch    = '0;
         cfg_fb_bytes = '0;
         for (int ch = 0; ch < N_CHAN; ch++) cfg_mask[ch] = RESET_MASK[ch];
         converted_q.delete();
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;

         // Screen sizes drop the bits above 14, then clip to the maximum
         if (csr_write_en) begin
            case (csr_index)
               REG_SCREEN_WIDTH:  cfg_width  = (csr_wdata[14:0] > SCREEN_DIM_MAX) ?
                                               dim_type'(SCREEN_DIM_MAX) : csr_wdata[14:0];
               REG_SCREEN_HEIGHT: cfg_height = (csr_wdata[14:0] > SCREEN_DIM_MAX) ?
                                               dim_type'(SCREEN_DIM_MAX) : csr_wdata[14:0];
               REG_LINE_PITCH:    cfg_pitch    = csr_wdata[14:0];
               REG_FB_SIZE_BYTES: cfg_fb_bytes = csr_wdata;
               REG_RED_MASK:      cfg_mask[CH_RED]   = csr_wdata;
               REG_GREEN_MASK:    cfg_mask[CH_GREEN] = csr_wdata;
               REG_BLUE_MASK:     cfg_mask[CH_BLUE]  = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            seen = '{req_action, req_pixel_col, req_pixel_row, req_color_in, req_fb_word_in};
            want = convert_pixel(seen);
            converted_q.push_back(want);
            pixels_taken++;
            if (seen.action == ACT_PUT) put_count++;
            else                        get_count++;
            if (want.in_range) on_screen++;
         end
         if (req_valid && !req_ready) stall_cycles++;

         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (converted_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing pending: in_range %b offset %h word %h",
                        $time, rsp_in_range, rsp_byte_offset, rsp_word_out);
            end else begin
               want = converted_q.pop_front();
               if (want.in_range !== rsp_in_range || want.byte_offset !== rsp_byte_offset ||
                   want.word_out !== rsp_word_out) begin
                  mismatches++;
                  $display("%0t: result %0d: expected in_range %b offset %h word %h, got %b %h %h",
                           $time, results_seen, want.in_range, want.byte_offset,
                           want.word_out, rsp_in_range, rsp_byte_offset, rsp_word_out);
               end
            end
         end
      end

      // Watchdog: drop the run if nothing moves on either channel for too long
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else                                                      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned setting;
      int unsigned made;
      int unsigned run;
      int unsigned col;
      int unsigned row;
      word_type    color;
      word_type    width;
      word_type    height;
      word_type    pitch;
      word_type    fb_bytes;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes are zero: nothing is on screen, offset still reported
      push_pixel(ACT_PUT, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
      push_pixel(ACT_GET, COORD_MAX, COORD_MAX, 32'h0000_0000, 32'hFFFF_FFFF);
      wait_idle();

      // Oversized screen writes clip to the maximum; largest framebuffer
      program_setting(32'hFFFF_FFFF, 32'd20000, 32'd16384, 32'hFFFF_FFFF,
                      RESET_MASK[CH_RED], RESET_MASK[CH_GREEN], RESET_MASK[CH_BLUE]);
      push_pixel(ACT_PUT, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 32'h0000_0000);
      push_pixel(ACT_GET, COORD_MAX, COORD_MAX, 32'h0000_0000, 32'hFFFF_FFFF);
      push_pixel(ACT_PUT, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
      push_pixel(ACT_GET, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
      push_pixel(ACT_PUT, 1, 8191, 32'h5AC3_3CA5, 32'hA5A5_A5A5);
      push_pixel(ACT_GET, 8192, 1, 32'h0000_0000, 32'h1234_5678);
      wait_idle();

      // RGB565 on a 100x50 screen; framebuffer ends exactly after pixel (98,49)
      program_setting(32'd100, 32'd50, 32'd128, (49 * 128 + 98) * 4 + 4,
                      32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
      push_pixel(ACT_PUT, 98, 49, 32'h00FF_8040, 32'hFFFF_0000);
      push_pixel(ACT_GET, 98, 49, 32'h0000_0000, 32'hDEAD_BEEF);
      push_pixel(ACT_PUT, 99, 49, 32'h00FF_FFFF, 32'h0000_0000);   // past framebuffer end
      push_pixel(ACT_GET, 100, 0, 32'h0000_0000, 32'hFFFF_FFFF);   // column off screen
      push_pixel(ACT_PUT, 0, 50, 32'h00FF_FFFF, 32'hFFFF_FFFF);    // row off screen
      push_pixel(ACT_GET, 0, 0, 32'h0000_0000, 32'h0000_FFFF);
      wait_idle();

      // Full-word mask, empty mask and a single top bit
      program_setting(32'd100, 32'd50, 32'd128, (49 * 128 + 98) * 4 + 4,
                      32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      push_pixel(ACT_PUT, 0, 0, 32'h00FF_FFFF, 32'h1234_5678);
      push_pixel(ACT_GET, 1, 1, 32'h0000_0000, 32'hFFFF_FFFF);
      push_pixel(ACT_GET, 2, 2, 32'h0000_0000, 32'h8000_0001);
      push_pixel(ACT_PUT, 3, 3, 32'h0080_8080, 32'h0000_0000);
      wait_idle();

      // Ragged mask, one-bit field, zero pitch
      program_setting(32'd16384, 32'd16384, 32'd0, 32'hFFFF_FFFF,
                      32'h0F0F_0000, 32'h0000_0001, 32'hC000_0000);
      push_pixel(ACT_PUT, COORD_MAX, COORD_MAX, 32'h00FF_FFFF, 32'h0000_0000);
      push_pixel(ACT_GET, COORD_MAX, 0, 32'h0000_0000, 32'hFFFF_FFFF);
      push_pixel(ACT_GET, 5, 5, 32'h0000_0000, 32'h0A05_0001);
      push_pixel(ACT_PUT, 7, 7, 32'h0080_0180, 32'hFFFF_FFFF);

      for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         // Sender mostly busy first, then receiver, then nobody idles
         if (setting < 2) begin
            send_idle_pct = 9;
            recv_idle_pct = 81;
         end else if (setting < 4) begin
            send_idle_pct = 81;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         if (setting == RANDOM_SETTINGS - 1) begin
            // Huge screen, some writes above the clip limit
            width    = $urandom_range(SCREEN_DIM_MAX - 64, 32767);
            height   = $urandom_range(SCREEN_DIM_MAX - 64, 32767);
            pitch    = $urandom_range(0, 32767);
            fb_bytes = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
         end else begin
            // Small screen; framebuffer ends around the last visible pixel
            width    = $urandom_range(8, 300);
            height   = $urandom_range(2, 200);
            pitch    = (setting == 2) ? $urandom_range(0, width) : width + $urandom_range(0, 8);
            fb_bytes = (pitch * (height - 1) + width) * 4
                       - 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
         end
         wait_idle();
         // Junk above bit 14 of the size registers must be dropped
         program_setting({17'($urandom()), 15'(width)}, {17'($urandom()), 15'(height)},
                         {17'($urandom()), 15'(pitch)}, fb_bytes,
                         random_mask(), random_mask(), random_mask());
         if (setting == PRESSURE_SETTING) pressure_arm = 1'b1;

         made = 0;
         while (made < ITEMS_PER_SETTING) begin
            if ($urandom_range(9) == 0) begin
               // Fill run: one color put along a row
               run   = $urandom_range(4, 16);
               col   = pick_coord(cfg_width);
               row   = pick_coord(cfg_height);
               color = $urandom();
               for (int i = 0; i < run; i++)
                  push_pixel(ACT_PUT, 14'(col + i), row, color, $urandom());
               made += run;
            end else begin
               push_pixel($urandom_range(1) ? ACT_GET : ACT_PUT, pick_coord(cfg_width),
                          pick_coord(cfg_height), $urandom(), $urandom());
               made++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Converted %0d pixels (%0d put, %0d get, %0d on screen) across %0d register settings;",
               pixels_taken, put_count, get_count, on_screen, settings_done);
      $display("input was held back for %0d cycles by result-side stalls.", stall_cycles);
      if (converted_q.size() != 0)
         $display("%0t: %0d predicted results never arrived", $time, converted_q.size());
      if (mismatches == 0 && converted_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
